FILE: rtl/lrfw_pkg.sv
// ----------------------------------------------------------------------------
// lrfw_pkg: shared types and constants of the log record flash writer
// Holds the item structs, the job passed from front to back, register
// indexes and the fixed markers and limits of the log layout.
// ----------------------------------------------------------------------------
package lrfw_pkg;

  localparam int AddrW       = 18;   // flash byte address width
  localparam int SumW        = 20;   // offset + base + shift at full precision
  localparam int DataW       = 48;
  localparam int CntW        = 3;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 18;
  localparam int QueueDepth  = 2;

  localparam int PageBytesDefault = 512;

  localparam logic [SumW-1:0] ShiftLimit = SumW'(20'h0FE00);
  localparam logic [SumW-1:0] ShiftBytes = SumW'(512);
  localparam logic [SumW-1:0] EndAddr    = SumW'(20'h243E0);
  localparam logic [SumW-1:0] HdrRecLen  = SumW'(16);   // header plus record
  localparam logic [SumW-1:0] RecLen     = SumW'(4);    // record only

  localparam logic [31:0] MarkTime = 32'h454D_4954;     // "TIME"
  localparam logic [31:0] MarkNext = 32'h5458_454E;     // "NEXT"
  localparam logic [15:0] PatA     = 16'd17742;
  localparam logic [15:0] PatB     = 16'd18772;
  localparam logic [15:0] HumBump  = 16'h0100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOG_BASE_ADDRESS = 1'b0,
    CFG_STOP_WHEN_FULL   = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic signed [15:0] temperature_q4;
    logic [11:0]        humidity_q4;
    logic [7:0]         pressure_rel;
    logic [47:0]        timestamp;
    logic [15:0]        record_period;
    logic               power_low;
    logic               usb_present;
    logic               stop_mode;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] flash_address;
    logic [DataW-1:0] write_data;
    logic [CntW-1:0]  byte_count;
    logic             last_write;
    logic             log_full;
  } out_item_t;

  // One classified event: everything the back end needs to emit its writes.
  typedef struct packed {
    logic [AddrW-1:0] start_addr;
    logic             header;
    logic             wrap;
    logic             full_before;
    logic [47:0]      timestamp;
    logic [15:0]      period;
    logic [15:0]      temp_word;
    logic [15:0]      hum_word;
  } job_t;

endpackage

FILE: rtl/lrfw_front.sv
// ----------------------------------------------------------------------------
// lrfw_front: event classifier
// Accepts events, decides header, shift and wrap, converts the measurements
// and owns the log state (offset, page remainder, period, overflow).
// ----------------------------------------------------------------------------
module lrfw_front #(
  parameter int PageBytes = lrfw_pkg::PageBytesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lrfw_pkg::in_item_t       in_item_i,
  input  logic [lrfw_pkg::AddrW-1:0] base_i,
  input  logic                     stop_full_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output lrfw_pkg::job_t           job_o
);
  import lrfw_pkg::*;

  localparam int RemW = $clog2(PageBytes);
  localparam logic [RemW:0] PageLim  = (RemW+1)'(PageBytes);
  localparam logic [RemW:0] HdrLimit = (RemW+1)'(PageBytes - 16);

  logic [AddrW-1:0] offset_q, offset_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [15:0]      prev_q, prev_d;
  logic             ovf_q, ovf_d;

  logic             accept, no_power, halted;
  logic [AddrW-1:0] off_al;
  logic [SumW-1:0]  sum0, shift_amt, start, rec_len, end_sum;
  logic             hdr, wrap;
  logic [RemW:0]    rem_sum;

  logic signed [20:0] t_ext, t_scaled, t_adj, t_div;
  logic [15:0]        t_word, h_word;
  logic [12:0]        h_sum;
  logic [7:0]         h_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign no_power   = (in_item_i.power_low && !in_item_i.usb_present) || in_item_i.stop_mode;
  assign halted     = ovf_q && stop_full_i;

  // Offsets only ever move in steps of four; keep the alignment explicit.
  assign off_al    = {offset_q[AddrW-1:2], 2'b00};
  assign sum0      = SumW'(off_al) + SumW'(base_i);
  assign shift_amt = (sum0 >= ShiftLimit) ? ShiftBytes : '0;
  assign start     = sum0 + shift_amt;
  assign hdr       = ((rem_q == '0) || (in_item_i.record_period != prev_q))
                     && ({1'b0, rem_q} <= HdrLimit);
  assign rec_len   = hdr ? HdrRecLen : RecLen;
  assign end_sum   = start + rec_len;
  assign wrap      = end_sum >= EndAddr;
  assign rem_sum   = {1'b0, rem_q} + (RemW+1)'(rec_len);

  // Temperature: value * 10 / 16 rounded by half, truncated toward zero.
  always_comb begin
    t_ext    = {{5{in_item_i.temperature_q4[15]}}, in_item_i.temperature_q4};
    t_scaled = (t_ext <<< 3) + (t_ext <<< 1) + 21'sd8;
    t_adj    = t_scaled[20] ? (t_scaled + 21'sd15) : t_scaled;
    t_div    = t_adj >>> 4;
    t_word   = t_div[15:0];
    if ((t_word == PatA) || (t_word == PatB)) begin
      t_word = t_word + 16'd1;
    end
  end

  // Humidity rounds to a byte and saturates; pressure goes in the high byte.
  always_comb begin
    h_sum  = {1'b0, in_item_i.humidity_q4} + 13'd8;
    h_byte = h_sum[12] ? 8'hFF : h_sum[11:4];
    h_word = {in_item_i.pressure_rel, h_byte};
    if ((h_word == PatA) || (h_word == PatB)) begin
      h_word = h_word + HumBump;
    end
  end

  always_comb begin
    offset_d = offset_q;
    rem_d    = rem_q;
    prev_d   = prev_q;
    ovf_d    = ovf_q;
    push_o   = 1'b0;
    if (accept) begin
      priority if (no_power) begin
        prev_d = '0;
      end else if (halted) begin
        // drop the event, state holds
      end else begin
        push_o = 1'b1;
        if (wrap) begin
          offset_d = '0;
          rem_d    = '0;
          prev_d   = '0;
          ovf_d    = 1'b1;
        end else begin
          offset_d = off_al + AddrW'(rec_len);
          rem_d    = (rem_sum >= PageLim) ? RemW'(rem_sum - PageLim) : rem_sum[RemW-1:0];
          prev_d   = hdr ? in_item_i.record_period : prev_q;
        end
      end
    end
  end

  always_comb begin
    job_o.start_addr  = start[AddrW-1:0];
    job_o.header      = hdr;
    job_o.wrap        = wrap;
    job_o.full_before = ovf_q;
    job_o.timestamp   = in_item_i.timestamp;
    job_o.period      = in_item_i.record_period;
    job_o.temp_word   = t_word;
    job_o.hum_word    = h_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      rem_q    <= '0;
      prev_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      offset_q <= offset_d;
      rem_q    <= rem_d;
      prev_q   <= prev_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

FILE: rtl/lrfw_queue.sv
// ----------------------------------------------------------------------------
// lrfw_queue: short job queue
// Two-entry FIFO between the classifier and the write sequencer.
// ----------------------------------------------------------------------------
module lrfw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrfw_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lrfw_pkg::job_t head_o
);
  import lrfw_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/lrfw_back.sv
// ----------------------------------------------------------------------------
// lrfw_back: flash write sequencer
// Steps through the writes of the head job, one per cycle, into an
// output register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module lrfw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  lrfw_pkg::job_t        job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lrfw_pkg::out_item_t   out_item_o
);
  import lrfw_pkg::*;

  typedef enum logic [2:0] {
    STEP_TIME,
    STEP_STAMP,
    STEP_PERIOD,
    STEP_TEMP,
    STEP_HUM,
    STEP_NEXT
  } step_e;

  step_e      step_q, step_cur, step_nxt;
  logic       started_q;
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic       load, last;
  logic [4:0] rel_addr;

  assign step_cur = started_q ? step_q : (job_i.header ? STEP_TIME : STEP_TEMP);
  assign load     = job_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    step_nxt   = STEP_TIME;
    last       = 1'b0;
    rel_addr   = '0;
    out_d      = '0;
    out_d.log_full = job_i.full_before;
    unique case (step_cur)
      STEP_TIME: begin
        step_nxt         = STEP_STAMP;
        out_d.write_data = {16'h0000, MarkTime};
        out_d.byte_count = 3'd4;
      end
      STEP_STAMP: begin
        step_nxt         = STEP_PERIOD;
        rel_addr         = 5'd4;
        out_d.write_data = job_i.timestamp;
        out_d.byte_count = 3'd6;
      end
      STEP_PERIOD: begin
        step_nxt         = STEP_TEMP;
        rel_addr         = 5'd10;
        out_d.write_data = {32'h0, job_i.period};
        out_d.byte_count = 3'd2;
      end
      STEP_TEMP: begin
        step_nxt         = STEP_HUM;
        rel_addr         = job_i.header ? 5'd12 : 5'd0;
        out_d.write_data = {32'h0, job_i.temp_word};
        out_d.byte_count = 3'd2;
      end
      STEP_HUM: begin
        step_nxt         = STEP_NEXT;
        last             = !job_i.wrap;
        rel_addr         = job_i.header ? 5'd14 : 5'd2;
        out_d.write_data = {32'h0, job_i.hum_word};
        out_d.byte_count = 3'd2;
      end
      STEP_NEXT: begin
        step_nxt         = STEP_TIME;
        last             = 1'b1;
        rel_addr         = job_i.header ? 5'd16 : 5'd4;
        out_d.write_data = {16'h0000, MarkNext};
        out_d.byte_count = 3'd4;
        out_d.log_full   = 1'b1;
      end
      default: begin
        step_nxt = STEP_TIME;
      end
    endcase
    out_d.flash_address = job_i.start_addr + AddrW'(rel_addr);
    out_d.last_write    = last;
  end

  assign pop_o       = load && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_TIME;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        started_q   <= !last;
        step_q      <= step_nxt;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/log_record_flash_writer.sv
// ----------------------------------------------------------------------------
// log_record_flash_writer: measurement events to flash write commands
// Turns each logged event into a page header (when due), a two-word record and,
// at the end of the log, a wrap marker, as a stream of flash writes.
// ----------------------------------------------------------------------------
// Path: a logged event's job is queued; its writes then leave via an output register.
// Throughput: one write per cycle while the consumer is ready; a logged event makes
//   2 to 6 writes; a dropped event makes none. Events transfer
//   every cycle while the two-entry job queue has room; the sequencer's
//   one-write-per-cycle pace sets the rate.
// Reset: clears log offset, page remainder, period, overflow flag, queue and
//   configuration registers at once; no clearing pass.
module log_record_flash_writer #(
  parameter int PageBytes = lrfw_pkg::PageBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [lrfw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lrfw_pkg::CfgDataW-1:0] cfg_wdata_i,
  // event input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lrfw_pkg::in_item_t            in_item_i,
  // flash write output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lrfw_pkg::out_item_t           out_item_o
);
  import lrfw_pkg::*;

  logic [AddrW-1:0] base_q;
  logic             stop_full_q;

  logic q_full, q_valid, q_push, q_pop;
  job_t push_job, head_job;

  // Configuration registers: user writes them only while idle; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      stop_full_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOG_BASE_ADDRESS: base_q      <= cfg_wdata_i[AddrW-1:0];
        CFG_STOP_WHEN_FULL:   stop_full_q <= cfg_wdata_i[0];
        default:              base_q      <= base_q;
      endcase
    end
  end

  // Front: classify each event and advance the log state on its transfer.
  lrfw_front #(
    .PageBytes (PageBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .base_i      (base_q),
    .stop_full_i (stop_full_q),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (push_job)
  );

  // Hold classified jobs so the front keeps taking events while writes drain.
  lrfw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // Back: emit the head job's writes, one transfer per cycle while the output is ready.
  lrfw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: sim/log_record_flash_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_record_flash_writer_tb: self-checking bench for the flash log writer
// Sends measurement events and register writes with random idling on both
// channels. An independent model of the log offset, page headers, marker
// bumps and log wrap predicts every flash write, and each write that comes
// out is compared field by field in arrival order.
// ----------------------------------------------------------------------------
package flash_log_check_pkg;
  import lrfw_pkg::*;

  localparam int unsigned PageSize   = 512;
  localparam int unsigned AlignMask  = 32'h3FFFC;
  localparam int unsigned AddrMask   = 32'h3FFFF;
  localparam int unsigned HighWindow = 32'h0FE00;
  localparam int unsigned HighSkip   = 512;
  localparam int unsigned LogEnd     = 32'h243E0;
  localparam logic [47:0] TimeMarker = 48'h0000_454D_4954;
  localparam logic [47:0] NextMarker = 48'h0000_5458_454E;
  localparam logic [15:0] ClashLo    = 16'd17742;
  localparam logic [15:0] ClashHi    = 16'd18772;
  localparam int unsigned MaxPrinted = 25;

  class flash_write_scoreboard;
    logic [17:0] base_addr;
    bit          halt_on_full;
    int unsigned offset;
    logic [15:0] last_period;
    bit          wrapped;
    out_item_t   expected_writes[$];
    int unsigned mismatches;
    int unsigned events;
    int unsigned dropped;
    int unsigned writes;
    int unsigned headers;
    int unsigned wraps;
    int unsigned clashes;

    function new();
      base_addr    = '0;
      halt_on_full = 1'b0;
      offset       = 0;
      last_period  = '0;
      wrapped      = 1'b0;
      mismatches   = 0;
      events       = 0;
      dropped      = 0;
      writes       = 0;
      headers      = 0;
      wraps        = 0;
      clashes      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == CFG_LOG_BASE_ADDRESS) begin
        base_addr = value;
      end else begin
        halt_on_full = value[0];
      end
    endfunction

    // Queue one write at the current offset and step past it.
    function void queue_write(logic [47:0] data, int unsigned nbytes, int unsigned skip);
      out_item_t w;
      w.flash_address = 18'(offset + base_addr + skip);
      w.write_data    = data;
      w.byte_count    = 3'(nbytes);
      w.last_write    = 1'b0;
      w.log_full      = wrapped;
      expected_writes.push_back(w);
      offset += nbytes;
    endfunction

    function void predict_writes(in_item_t ev);
      int unsigned skip;
      int unsigned in_page;
      int unsigned hum_round;
      int          temp_full;
      int          tenths;
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      out_item_t   tail;
      events++;
      if ((ev.power_low && !ev.usb_present) || ev.stop_mode) begin
        last_period = '0;
        dropped++;
        return;
      end
      if (wrapped && halt_on_full) begin
        dropped++;
        return;
      end
      offset  = offset & AlignMask;
      skip    = (offset + base_addr >= HighWindow) ? HighSkip : 0;
      in_page = offset % PageSize;
      if ((in_page == 0 || ev.record_period != last_period) && in_page <= PageSize - 16) begin
        queue_write(TimeMarker, 4, skip);
        queue_write(ev.timestamp, 6, skip);
        queue_write(48'(ev.record_period), 2, skip);
        last_period = ev.record_period;
        headers++;
      end
      // tenths of a degree, half step added, truncated toward zero
      temp_full = int'($signed(ev.temperature_q4));
      tenths    = (temp_full * 10 + 8) / 16;
      temp_word = tenths[15:0];
      if (temp_word == ClashLo || temp_word == ClashHi) begin
        temp_word += 16'd1;
        clashes++;
      end
      queue_write(48'(temp_word), 2, skip);
      hum_round = (32'(ev.humidity_q4) + 8) >> 4;
      if (hum_round > 255) begin
        hum_round = 255;
      end
      hum_word = {ev.pressure_rel, hum_round[7:0]};
      if (hum_word == ClashLo || hum_word == ClashHi) begin
        hum_word += 16'h0100;
        clashes++;
      end
      queue_write(48'(hum_word), 2, skip);
      if (offset + base_addr + skip >= LogEnd) begin
        wrapped = 1'b1;
        queue_write(NextMarker, 4, skip);
        offset      = 0;
        last_period = '0;
        wraps++;
      end
      offset = offset & AddrMask;
      tail = expected_writes.pop_back();
      tail.last_write = 1'b1;
      expected_writes.push_back(tail);
    endfunction

    task report(string what, logic [47:0] want, logic [47:0] got);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
      end
    endtask

    task check_write(out_item_t got);
      out_item_t want;
      writes++;
      if (expected_writes.size() == 0) begin
        report("unexpected write, address", '0, 48'(got.flash_address));
        return;
      end
      want = expected_writes.pop_front();
      if (got.flash_address !== want.flash_address) begin
        report("flash_address", 48'(want.flash_address), 48'(got.flash_address));
      end
      if (got.write_data !== want.write_data) begin
        report("write_data", want.write_data, got.write_data);
      end
      if (got.byte_count !== want.byte_count) begin
        report("byte_count", 48'(want.byte_count), 48'(got.byte_count));
      end
      if (got.last_write !== want.last_write) begin
        report("last_write", 48'(want.last_write), 48'(got.last_write));
      end
      if (got.log_full !== want.log_full) begin
        report("log_full", 48'(want.log_full), 48'(got.log_full));
      end
    endtask
  endclass

endpackage

module log_record_flash_writer_tb;
  import lrfw_pkg::*;
  import flash_log_check_pkg::*;

  // Longest stretch without any transfer before the run is declared hung.
  localparam int QuietLimit   = 2000;
  // Cycles to let pass after the last expected write before touching the
  // registers, so that the job queue and the output register have emptied.
  localparam int SettleCycles = 12;

  // Flag sets for {power_low, usb_present, stop_mode}.
  localparam logic [2:0] Awake       = 3'b000;
  localparam logic [2:0] LowNoUsb    = 3'b100;
  localparam logic [2:0] LowOnUsb    = 3'b110;
  localparam logic [2:0] StopOnUsb   = 3'b011;
  localparam logic [2:0] AllRaised   = 3'b111;
  localparam logic [2:0] LowStopBare = 3'b101;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;

  flash_write_scoreboard flash_sb;

  logic [15:0] cur_period;
  int          burst_left;
  int          stall_left = 0;
  int          calm_left  = 0;
  int          quiet_cycles = 0;

  log_record_flash_writer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length for either side: mostly a short one, now and then a long one.
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Receiver: stall at random, with calm stretches where every write is
  // taken at once. Drive on the falling edge only.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 99) < 2) begin
        calm_left <= $urandom_range(20, 120);
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left <= idle_span();
      end
    end
  end

  // Monitor: sample both channels and the register port at the rising edge,
  // predict on every accepted event, check every accepted write, and watch
  // for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        flash_sb.set_reg(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        flash_sb.predict_writes(in_item);
      end
      if (out_valid && out_ready) begin
        flash_sb.check_write(out_item);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d writes outstanding",
                 quiet_cycles, flash_sb.expected_writes.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one event after an optional gap; hold it until the transfer.
  task automatic send_event(in_item_t ev, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_inputs();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_writes();
    while (flash_sb.expected_writes.size() != 0) @(posedge clk);
  endtask

  // Drop valid, let every predicted write arrive, then wait SettleCycles.
  task automatic settle();
    hold_inputs();
    drain_writes();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t make_event(logic [15:0] temp, logic [11:0] hum,
                                          logic [7:0] pres, logic [47:0] stamp,
                                          logic [15:0] period, logic [2:0] flags);
    in_item_t ev;
    ev.temperature_q4 = temp;
    ev.humidity_q4    = hum;
    ev.pressure_rel   = pres;
    ev.timestamp      = stamp;
    ev.record_period  = period;
    {ev.power_low, ev.usb_present, ev.stop_mode} = flags;
    return ev;
  endfunction

  // Mostly awake events with a steady period and random readings; marker
  // clashes, extremes, period changes and sleep flags mixed in.
  function automatic in_item_t random_event();
    in_item_t    ev;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      ev.temperature_q4 = 16'sd28387;
    end else if (roll < 10) begin
      ev.temperature_q4 = 16'sd30035;
    end else if (roll < 15) begin
      ev.temperature_q4 = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    end else if (roll < 60) begin
      ev.temperature_q4 = 16'($urandom_range(0, 1600)) - 16'd400;
    end else begin
      ev.temperature_q4 = 16'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      ev.humidity_q4  = 12'd1248;
      ev.pressure_rel = 8'h45;
    end else if (roll < 10) begin
      ev.humidity_q4  = 12'd1344;
      ev.pressure_rel = 8'h49;
    end else begin
      ev.humidity_q4  = (roll < 16) ? 12'hFFF : 12'($urandom_range(0, 4095));
      ev.pressure_rel = 8'($urandom);
    end
    ev.timestamp = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 99) < 8) begin
      cur_period = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    end
    ev.record_period = cur_period;
    if ($urandom_range(0, 99) < 85) begin
      ev.power_low   = 1'b0;
      ev.usb_present = 1'($urandom);
      ev.stop_mode   = 1'b0;
    end else begin
      {ev.power_low, ev.usb_present, ev.stop_mode} = 3'($urandom);
    end
    return ev;
  endfunction

  task automatic run_random(int count);
    int gap;
    for (int k = 0; k < count; k++) begin
      // now and then hold off until every pending write has drained
      if ($urandom_range(0, 49) == 0) begin
        hold_inputs();
        drain_writes();
      end
      if (burst_left != 0) begin
        burst_left--;
        gap = 0;
      end else if ($urandom_range(0, 29) == 0) begin
        burst_left = $urandom_range(10, 40);
        gap = 0;
      end else begin
        gap = ($urandom_range(0, 99) < 50) ? 0 : idle_span();
      end
      send_event(random_event(), gap);
    end
  endtask

  task automatic run_directed();
    // fresh page: header, then zero readings
    send_event(make_event(16'h0000, 12'd0, 8'h00, 48'h0, 16'h0000, Awake), 0);
    // all maxima; the period change forces a header mid page
    send_event(make_event(16'h7FFF, 12'hFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                          Awake), 0);
    // most negative temperature; humidity rounding past 255 saturates
    send_event(make_event(16'h8000, 12'd4088, 8'h00, 48'h1, 16'hFFFF, Awake), 0);
    // minus one sixteenth rounds to zero, humidity rounds down to zero
    send_event(make_event(16'hFFFF, 12'd7, 8'h80, 48'h8000_0000_0000, 16'hFFFF, Awake), 0);
    // both words land on the low marker pattern
    send_event(make_event(16'd28387, 12'd1248, 8'h45, 48'h0123_4567_89AB, 16'hFFFF,
                          Awake), 0);
    // both words land on the high marker pattern
    send_event(make_event(16'd30035, 12'd1344, 8'h49, 48'hFEDC_BA98_7654, 16'hFFFF,
                          Awake), 0);
    // half steps: humidity rounds up; negative temperature truncates toward zero
    send_event(make_event(16'd8, 12'd8, 8'h01, 48'h2, 16'hFFFF, Awake), 0);
    send_event(make_event(16'hFFF8, 12'd24, 8'h7F, 48'h3, 16'hFFFF, Awake), 0);
    // power low on battery: no writes, period forgotten
    send_event(make_event(16'd400, 12'd800, 8'h10, 48'h4, 16'hFFFF, LowNoUsb), 2);
    // same period again still gets a header after the forget
    send_event(make_event(16'd401, 12'd801, 8'h11, 48'h5, 16'hFFFF, Awake), 1);
    // stop mode wins even with USB present
    send_event(make_event(16'd402, 12'd802, 8'h12, 48'h6, 16'hFFFF, StopOnUsb), 0);
    // power low but on USB: logging goes on; with stop mode added, the event is dropped
    send_event(make_event(16'd403, 12'd803, 8'h13, 48'h7, 16'hFFFF, LowOnUsb), 3);
    send_event(make_event(16'd404, 12'd804, 8'h14, 48'h8, 16'hFFFF, AllRaised), 0);
    send_event(make_event(16'd405, 12'd805, 8'h15, 48'h9, 16'hFFFF, LowStopBare), 0);
    // period changes to a new value and back to zero
    send_event(make_event(16'd406, 12'd806, 8'h16, 48'hA, 16'h1234, Awake), 5);
    send_event(make_event(16'd407, 12'd807, 8'h17, 48'hB, 16'h0000, Awake), 0);
    // alternating bit patterns in every field
    send_event(make_event(16'h5A5A, 12'hA5A, 8'h5A, 48'hA5A5_5A5A_A5A5, 16'hA5A5,
                          Awake), 0);
    send_event(make_event(16'hA5A5, 12'h5A5, 8'hA5, 48'h5A5A_A5A5_5A5A, 16'h5A5A,
                          Awake), 0);
  endtask

  initial begin
    flash_sb   = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LOG_BASE_ADDRESS;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_item    = '0;
    cur_period = 16'd0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // registers at their reset values: base 0, keep wrapping
    run_directed();
    settle();

    // stop-on-full armed before the log ever fills: must change nothing
    write_reg(CFG_STOP_WHEN_FULL, 18'd1);
    run_random(130);
    settle();

    // base close to the end of the log and above the high window: the
    // offset wraps every 256 bytes with a NEXT marker
    write_reg(CFG_LOG_BASE_ADDRESS, 18'h240E0);
    write_reg(CFG_STOP_WHEN_FULL, 18'd0);
    run_random(80);
    settle();

    // log is full now; with stop-on-full every event is swallowed
    write_reg(CFG_STOP_WHEN_FULL, 18'd1);
    run_random(20);
    settle();

    // largest base: every event wraps and addresses spill past 18 bits
    write_reg(CFG_STOP_WHEN_FULL, 18'd0);
    write_reg(CFG_LOG_BASE_ADDRESS, 18'h3FFFF);
    run_random(25);
    settle();

    // base just below the high window: the 512-byte skip kicks in mid run
    write_reg(CFG_LOG_BASE_ADDRESS, 18'h0FDC0);
    run_random(60);
    settle();

    write_reg(CFG_LOG_BASE_ADDRESS, 18'($urandom_range(0, 32'h23000)));
    run_random(60);
    settle();

    $display("Covered %0d events (%0d dropped for sleep or full log), %0d writes checked",
             flash_sb.events, flash_sb.dropped, flash_sb.writes);
    $display("  with %0d page headers, %0d log wraps, %0d marker bumps, %0d mismatches",
             flash_sb.headers, flash_sb.wraps, flash_sb.clashes, flash_sb.mismatches);
    if (flash_sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lrfw_pkg.sv
rtl/lrfw_front.sv
rtl/lrfw_queue.sv
rtl/lrfw_back.sv
rtl/log_record_flash_writer.sv
sim/log_record_flash_writer_tb.sv
